@@ design/rms_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_pkg: shared types and constants for the running mean / std-dev core
// Holds the controller state enum, the command/status structs between the
// controller and the datapath, the result word layout and fixed widths.
// ----------------------------------------------------------------------------
package rms_pkg;

    // Widths of the spread accumulator, divider and result, and sqrt constants
    localparam int M2_W        = 64;
    localparam int DIV_W       = 64;
    localparam int EXT_W       = 128;
    localparam int OUT_W       = 32;
    localparam int ITER_W      = 7;
    localparam int SQRT_STEPS  = 32;
    localparam logic [M2_W-1:0] SQRT_BIT_INIT = 64'h4000_0000_0000_0000;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_DIV_MEAN,
        ST_MEAN,
        ST_MUL_LOAD,
        ST_MUL,
        ST_ACC,
        ST_VAR_LOAD,
        ST_DIV_VAR,
        ST_SQRT_LOAD,
        ST_SQRT,
        ST_RESULT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic div_mean_load;
        logic div_step;
        logic mean_upd;
        logic mul_load;
        logic mul_step;
        logic acc;
        logic var_load;
        logic sqrt_load;
        logic sqrt_step;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic iter_done;
        logic count_gt1;
        logic out_free;
    } t_dp_sts;

    // One result word
    typedef struct packed {
        logic        [OUT_W-1:0] sample_count;
        logic signed [OUT_W-1:0] running_mean;
        logic        [OUT_W-1:0] std_deviation;
        logic                    spread_saturated;
    } t_result;

endpackage

@@ design/rms_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_in_if: sample channel
// Valid/ready channel that carries one signed Q16.16 sample per word.
// ----------------------------------------------------------------------------
interface rms_in_if #(
    parameter int SAMPLE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

@@ design/rms_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_out_if: result channel
// Valid/ready channel that carries count, mean, std deviation and the
// saturation flag for each processed sample.
// ----------------------------------------------------------------------------
interface rms_out_if;
    logic               valid;
    logic               ready;
    logic        [31:0] sample_count;
    logic signed [31:0] running_mean;
    logic        [31:0] std_deviation;
    logic               spread_saturated;

    modport source (output valid, output sample_count, output running_mean,
                    output std_deviation, output spread_saturated, input ready);
    modport sink   (input valid, input sample_count, input running_mean,
                    input std_deviation, input spread_saturated, output ready);
endinterface

@@ design/running_mean_stddev_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_mean_stddev_core: online mean and sample standard deviation
// Welford update over a stream of signed Q16.16 samples.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one sample word; o_out carries one result word per sample
//   with the saturating count, the Q16.16 mean, the Q16.16 sample standard
//   deviation (zero while the count is at most one) and a sticky flag that
//   is set once the squared-deviation sum has clipped at its maximum.
//   A sample is taken only while the core is idle and out of reset. Each
//   sample runs through a serial datapath: a one-bit-per-cycle divider for
//   the mean step, a shift-add multiplier, the same divider for
//   M2 / (count - 1) and a bitwise square root, with load and update
//   states between them. When the count is at most one the divide and
//   square root are skipped. The result sits in an output register; a new
//   sample is accepted while it waits. If the receiver stalls, the next
//   result holds in the core until the register frees, and no further
//   sample is taken meanwhile. Synchronous reset clears count, mean, M2
//   and the flag and empties the output register.
// ----------------------------------------------------------------------------
module running_mean_stddev_core
    import rms_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32,
    parameter int COUNT_WIDTH  = 32
) (
    input logic       i_clk,
    input logic       i_rst_n,
    rms_in_if.sink    i_in,
    rms_out_if.source o_out
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;
    logic    w_out_valid;
    t_result w_result;

    rms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rms_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_sample    (i_in.sample),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .o_result    (w_result)
    );

    // Channel hookup
    assign i_in.ready             = w_in_ready;
    assign o_out.valid            = w_out_valid;
    assign o_out.sample_count     = w_result.sample_count;
    assign o_out.running_mean     = w_result.running_mean;
    assign o_out.std_deviation    = w_result.std_deviation;
    assign o_out.spread_saturated = w_result.spread_saturated;

    // A taken sample blocks the input until its result is handed off
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while a sample is in work");

    // Iterative units only step while iterations remain
    a_step_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.div_step || w_cmd.mul_step || w_cmd.sqrt_step) |-> !w_sts.iter_done)
        else $error("iteration step issued with no iterations left");

    // Load commands never collide
    a_loads_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.accept, w_cmd.div_mean_load, w_cmd.var_load,
                  w_cmd.mul_load, w_cmd.sqrt_load, w_cmd.out_load}))
        else $error("more than one datapath load in a cycle");

    // A result is only loaded when the output register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out.valid || o_out.ready))
        else $error("result register overwritten before it was taken");

endmodule

@@ design/rms_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_ctrl: sequencing state machine
// Walks one sample through delta, mean divide, mean update, serial multiply,
// accumulate, variance divide and square root if count > 1, hands off result.
// ----------------------------------------------------------------------------
module rms_ctrl
    import rms_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (i_in_valid) n_state = ST_DELTA;
            ST_DELTA:     n_state = ST_DIV_MEAN;
            ST_DIV_MEAN:  if (i_sts.iter_done) n_state = ST_MEAN;
            ST_MEAN:      n_state = ST_MUL_LOAD;
            ST_MUL_LOAD:  n_state = ST_MUL;
            ST_MUL:       if (i_sts.iter_done) n_state = ST_ACC;
            ST_ACC:       n_state = i_sts.count_gt1 ? ST_VAR_LOAD : ST_RESULT;
            ST_VAR_LOAD:  n_state = ST_DIV_VAR;
            ST_DIV_VAR:   if (i_sts.iter_done) n_state = ST_SQRT_LOAD;
            ST_SQRT_LOAD: n_state = ST_SQRT;
            ST_SQRT:      if (i_sts.iter_done) n_state = ST_RESULT;
            ST_RESULT:    if (i_sts.out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // Outputs; no word is taken while reset is held
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = i_rst_n;
                o_cmd.accept = i_in_valid && i_rst_n;
            end
            ST_DELTA:     o_cmd.div_mean_load = 1'b1;
            ST_DIV_MEAN:  o_cmd.div_step      = !i_sts.iter_done;
            ST_MEAN:      o_cmd.mean_upd      = 1'b1;
            ST_MUL_LOAD:  o_cmd.mul_load      = 1'b1;
            ST_MUL:       o_cmd.mul_step      = !i_sts.iter_done;
            ST_ACC:       o_cmd.acc           = 1'b1;
            ST_VAR_LOAD:  o_cmd.var_load      = 1'b1;
            ST_DIV_VAR:   o_cmd.div_step      = !i_sts.iter_done;
            ST_SQRT_LOAD: o_cmd.sqrt_load     = 1'b1;
            ST_SQRT:      o_cmd.sqrt_step     = !i_sts.iter_done;
            ST_RESULT:    o_cmd.out_load      = i_sts.out_free;
            default:      o_cmd = '0;
        endcase
    end

endmodule

@@ design/rms_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_dp: Welford datapath
// Holds count, mean and M2, a shared restoring divider, a shift-add
// multiplier, a bitwise integer square root and the output register.
// ----------------------------------------------------------------------------
module rms_dp
    import rms_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_dp_cmd                        i_cmd,
    output t_dp_sts                        o_sts,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output t_result                        o_result
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int CW = COUNT_WIDTH;

    // Architectural state
    logic        [CW-1:0]   r_count, n_count;
    logic signed [SW-1:0]   r_mean,  n_mean;
    logic        [M2_W-1:0] r_m2,    n_m2;
    logic                   r_sat,   n_sat;

    // Working registers
    logic signed [SW-1:0]   r_x,       n_x;
    logic                   r_neg,     n_neg;
    logic        [SW-1:0]   r_mag,     n_mag;
    logic        [ITER_W-1:0] r_iter,  n_iter;
    logic        [DIV_W-1:0] r_dq,     n_dq;
    logic        [CW-1:0]   r_rem,     n_rem;
    logic        [CW-1:0]   r_divisor, n_divisor;
    logic        [2*SW-1:0] r_prod,    n_prod;
    logic        [M2_W-1:0] r_sq_v,    n_sq_v;
    logic        [M2_W-1:0] r_root,    n_root;
    logic        [M2_W-1:0] r_bit,     n_bit;
    logic                   r_out_valid, n_out_valid;
    t_result                r_result,  n_result;

    // Combinational helpers
    logic signed [SW:0]     w_delta;
    logic signed [SW:0]     w_delta_neg;
    logic        [SW-1:0]   w_mag;
    logic        [CW:0]     w_trial;
    logic        [CW:0]     w_diff;
    logic                   w_ge;
    logic signed [SW:0]     w_mean_ext;
    logic signed [SW:0]     w_mean_sum;
    logic        [SW-1:0]   w_q;
    logic        [SW:0]     w_mul_sum;
    logic        [EXT_W-1:0] w_prod_ext;
    logic        [M2_W:0]   w_m2_sum;
    logic        [M2_W-1:0] w_sq_trial;

    // Deviation of the latched sample from the current mean
    assign w_delta     = {r_x[SW-1], r_x} - {r_mean[SW-1], r_mean};
    assign w_delta_neg = -w_delta;
    assign w_mag       = w_delta[SW] ? w_delta_neg[SW-1:0] : w_delta[SW-1:0];

    // Restoring divider step
    assign w_trial = {r_rem, r_dq[DIV_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_divisor});
    assign w_diff  = w_trial - {1'b0, r_divisor};

    // Mean move by the truncated quotient
    assign w_q        = r_dq[SW-1:0];
    assign w_mean_ext = {r_mean[SW-1], r_mean};
    assign w_mean_sum = r_neg ? (w_mean_ext - $signed({1'b0, w_q}))
                              : (w_mean_ext + $signed({1'b0, w_q}));

    // Shift-add multiplier step
    assign w_mul_sum = {1'b0, r_prod[2*SW-1:SW]} + (r_prod[0] ? {1'b0, r_mag} : '0);

    // M2 accumulate with overflow detect
    assign w_prod_ext = EXT_W'(r_prod);
    assign w_m2_sum   = {1'b0, r_m2} + {1'b0, w_prod_ext[M2_W-1:0]};

    // Square root trial
    assign w_sq_trial = r_root + r_bit;

    // Next values
    always_comb begin
        n_count     = r_count;
        n_mean      = r_mean;
        n_m2        = r_m2;
        n_sat       = r_sat;
        n_x         = r_x;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_iter      = r_iter;
        n_dq        = r_dq;
        n_rem       = r_rem;
        n_divisor   = r_divisor;
        n_prod      = r_prod;
        n_sq_v      = r_sq_v;
        n_root      = r_root;
        n_bit       = r_bit;
        n_result    = r_result;
        n_out_valid = r_out_valid;

        if (i_cmd.accept) begin
            n_x     = i_sample;
            n_count = (&r_count) ? r_count : r_count + 1'b1;
        end

        if (i_cmd.div_mean_load) begin
            n_neg     = w_delta[SW];
            n_mag     = w_mag;
            n_dq      = DIV_W'(w_mag) << (DIV_W - SW);
            n_rem     = '0;
            n_divisor = r_count;
            n_iter    = ITER_W'(SW);
        end

        if (i_cmd.var_load) begin
            n_dq      = r_m2;
            n_rem     = '0;
            n_divisor = r_count - 1'b1;
            n_iter    = ITER_W'(DIV_W);
        end

        if (i_cmd.div_step) begin
            n_rem  = w_ge ? w_diff[CW-1:0] : w_trial[CW-1:0];
            n_dq   = {r_dq[DIV_W-2:0], w_ge};
            n_iter = r_iter - 1'b1;
        end

        if (i_cmd.mean_upd) begin
            n_mean = w_mean_sum[SW-1:0];
        end

        if (i_cmd.mul_load) begin
            n_prod = {{SW{1'b0}}, w_mag};
            n_iter = ITER_W'(SW);
        end

        if (i_cmd.mul_step) begin
            n_prod = {w_mul_sum, r_prod[SW-1:1]};
            n_iter = r_iter - 1'b1;
        end

        // M2 sticks at all ones once it overflows
        if (i_cmd.acc) begin
            if ((|w_prod_ext[EXT_W-1:M2_W]) || w_m2_sum[M2_W]) begin
                n_m2  = '1;
                n_sat = 1'b1;
            end else begin
                n_m2  = w_m2_sum[M2_W-1:0];
            end
            n_root = '0;
        end

        if (i_cmd.sqrt_load) begin
            n_sq_v = r_dq;
            n_root = '0;
            n_bit  = SQRT_BIT_INIT;
            n_iter = ITER_W'(SQRT_STEPS);
        end

        if (i_cmd.sqrt_step) begin
            if (r_sq_v >= w_sq_trial) begin
                n_sq_v = r_sq_v - w_sq_trial;
                n_root = (r_root >> 1) + r_bit;
            end else begin
                n_root = r_root >> 1;
            end
            n_bit  = r_bit >> 2;
            n_iter = r_iter - 1'b1;
        end

        // Output register: cleared when taken, reloaded on a new result
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.out_load) begin
            n_out_valid               = 1'b1;
            n_result.sample_count     = OUT_W'(r_count);
            n_result.running_mean     = OUT_W'(r_mean);
            n_result.std_deviation    = r_root[OUT_W-1:0];
            n_result.spread_saturated = r_sat;
        end
    end

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_mean      <= '0;
            r_m2        <= '0;
            r_sat       <= 1'b0;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_mean      <= n_mean;
            r_m2        <= n_m2;
            r_sat       <= n_sat;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_x       <= n_x;
        r_neg     <= n_neg;
        r_mag     <= n_mag;
        r_dq      <= n_dq;
        r_rem     <= n_rem;
        r_divisor <= n_divisor;
        r_prod    <= n_prod;
        r_sq_v    <= n_sq_v;
        r_root    <= n_root;
        r_bit     <= n_bit;
        r_result  <= n_result;
    end

    // Status
    assign o_sts.iter_done = (r_iter == '0);
    assign o_sts.count_gt1 = (r_count > CW'(1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule
